// ----- sv/lmaw_pkg.sv -----
// Shared constants, payload types and work-record types for the majority-window block.
package lmaw_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int POS_W      = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W      = POS_W + 1;
    localparam int DATA_W     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(1);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_POS,
        KIND_LOOKUP,
        KIND_OVF
    } t_kind;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     first_item;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] best_length;
        logic             overflow;
    } t_out_item;

    typedef struct packed {
        t_kind            kind;
        logic             first;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tdata;
    } t_work;

endpackage

// ----- sv/lmaw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lmaw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lmaw_front.sv -----
// Front end: threshold register, prefix-sum state, first-seen table and classification.
module lmaw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [lmaw_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                             i_accept,
    input  lmaw_pkg::t_in_item               i_item,
    output logic                             o_work_valid,
    output lmaw_pkg::t_work                  o_work
);

    logic signed [lmaw_pkg::DATA_W-1:0] r_threshold;
    logic signed [lmaw_pkg::SUM_W-1:0]  r_sum;
    logic signed [lmaw_pkg::SUM_W-1:0]  r_low;
    logic [lmaw_pkg::POS_W-1:0]         r_pos;

    logic                               r_s1_valid;
    lmaw_pkg::t_kind                    r_s1_kind;
    logic                               r_s1_first;
    logic [lmaw_pkg::IDX_W-1:0]         r_s1_idx;

    logic signed [lmaw_pkg::SUM_W-1:0]  cur_sum;
    logic signed [lmaw_pkg::SUM_W-1:0]  cur_low;
    logic [lmaw_pkg::POS_W-1:0]         cur_pos;
    logic signed [lmaw_pkg::SUM_W-1:0]  sum_n;
    logic signed [lmaw_pkg::SUM_W-1:0]  neg_sum;
    logic signed [lmaw_pkg::SUM_W-1:0]  neg_sum_m1;
    logic                               above;
    logic                               ovf;
    logic                               sum_pos;
    logic                               do_read;
    logic                               do_write;
    lmaw_pkg::t_kind                    kind;
    logic [lmaw_pkg::IDX_W-1:0]         rdata;

    always_comb begin
        cur_sum    = i_item.first_item ? '0 : r_sum;
        cur_low    = i_item.first_item ? '0 : r_low;
        cur_pos    = i_item.first_item ? '0 : r_pos;
        above      = i_item.sample_value > r_threshold;
        ovf        = cur_pos == lmaw_pkg::POS_W'(lmaw_pkg::MAX_ITEMS);
        sum_n      = above ? cur_sum + lmaw_pkg::SUM_ONE : cur_sum - lmaw_pkg::SUM_ONE;
        neg_sum    = -sum_n;
        neg_sum_m1 = neg_sum - lmaw_pkg::SUM_ONE;
        sum_pos    = !sum_n[lmaw_pkg::SUM_W-1] && (sum_n != '0);
        // sum - 1 already reached: its first position is in the table
        do_read    = !ovf && !sum_pos && (sum_n > cur_low);
        // new minimum: record where this sum first showed up
        do_write   = !ovf && (sum_n < cur_low);
        priority if (ovf) begin
            kind = lmaw_pkg::KIND_OVF;
        end else if (sum_pos) begin
            kind = lmaw_pkg::KIND_POS;
        end else if (do_read) begin
            kind = lmaw_pkg::KIND_LOOKUP;
        end else begin
            kind = lmaw_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_sum       <= '0;
            r_low       <= '0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_data;
            end
            if (i_accept && !ovf) begin
                r_sum <= sum_n;
                r_low <= do_write ? sum_n : cur_low;
                r_pos <= cur_pos + lmaw_pkg::POS_W'(1);
            end
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_kind  <= kind;
            r_s1_first <= i_item.first_item;
            r_s1_idx   <= cur_pos[lmaw_pkg::IDX_W-1:0];
        end
    end

    lmaw_ram #(
        .WIDTH (lmaw_pkg::IDX_W),
        .DEPTH (lmaw_pkg::MAX_ITEMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_accept && do_write),
        .i_waddr (neg_sum_m1[lmaw_pkg::IDX_W-1:0]),
        .i_wdata (cur_pos[lmaw_pkg::IDX_W-1:0]),
        .i_re    (i_accept && do_read),
        .i_raddr (neg_sum[lmaw_pkg::IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign o_work_valid = r_s1_valid;
    assign o_work       = '{kind: r_s1_kind, first: r_s1_first, idx: r_s1_idx, tdata: rdata};

endmodule

// ----- sv/lmaw_fifo.sv -----
// Short work queue between front end and back end.
module lmaw_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  lmaw_pkg::t_work              i_data,
    input  logic                         i_pop,
    output lmaw_pkg::t_work              o_data,
    output logic                         o_empty,
    output logic [lmaw_pkg::FIFO_CW-1:0] o_count
);

    lmaw_pkg::t_work                r_mem [lmaw_pkg::FIFO_DEPTH];
    logic [lmaw_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [lmaw_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [lmaw_pkg::FIFO_CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lmaw_pkg::FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + lmaw_pkg::FIFO_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + lmaw_pkg::FIFO_CW'(1);
                2'b01:   r_count <= r_count - lmaw_pkg::FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

endmodule

// ----- sv/lmaw_back.sv -----
// Back end: best-window update and result register.
module lmaw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_work_valid,
    input  lmaw_pkg::t_work     i_work,
    output logic                o_work_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output lmaw_pkg::t_out_item o_item
);

    logic [lmaw_pkg::POS_W-1:0] r_best;
    logic                       r_out_valid;
    lmaw_pkg::t_out_item        r_out;

    logic                       advance;
    logic [lmaw_pkg::POS_W-1:0] base;
    logic [lmaw_pkg::POS_W-1:0] pos_plus;
    logic [lmaw_pkg::IDX_W-1:0] diff;
    logic [lmaw_pkg::POS_W-1:0] len;
    logic [lmaw_pkg::POS_W-1:0] best_n;
    logic                       ovf_n;

    always_comb begin
        advance  = i_work_valid && (!r_out_valid || i_pop);
        base     = i_work.first ? '0 : r_best;
        pos_plus = lmaw_pkg::POS_W'(i_work.idx) + lmaw_pkg::POS_W'(1);
        diff     = i_work.idx - i_work.tdata;
        len      = lmaw_pkg::POS_W'(diff);
        ovf_n    = 1'b0;
        unique case (i_work.kind)
            lmaw_pkg::KIND_OVF: begin
                best_n = r_best;
                ovf_n  = 1'b1;
            end
            lmaw_pkg::KIND_POS: begin
                best_n = pos_plus;
            end
            lmaw_pkg::KIND_LOOKUP: begin
                best_n = (len > base) ? len : base;
            end
            lmaw_pkg::KIND_NONE: begin
                best_n = base;
            end
            default: begin
                best_n = base;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_best      <= best_n;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until popped
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= '{best_length: best_n, overflow: ovf_n};
        end
    end

    assign o_work_pop = advance;
    assign o_empty    = !r_out_valid;
    assign o_item     = r_out;

endmodule

// ----- sv/longest_majority_above_window.sv -----
// Longest majority-above window: top level joining front end, work queue and back end.
// Path: an accepted item passes the table-read stage and the work queue into the result register.
// Throughput: one item per cycle while full is low; the first-seen table takes one read and one write per cycle.
// Full is high when the work queue plus the table-read stage hold four or more entries.
// Reset: synchronous, active low; clears sums, position, best length, threshold and queues.
// The first-seen table needs no clearing pass: an entry is read only after it was written.
module longest_majority_above_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  lmaw_pkg::t_in_item          i_push_item,
    output logic                        empty,
    input  logic                        pop,
    output lmaw_pkg::t_out_item         o_pop_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lmaw_pkg::DATA_W-1:0] i_cfg_data
);

    logic                         accept;
    logic                         work_valid;
    lmaw_pkg::t_work              work_in;
    lmaw_pkg::t_work              work_out;
    logic                         fifo_empty;
    logic                         fifo_pop;
    logic [lmaw_pkg::FIFO_CW-1:0] fifo_count;
    logic [lmaw_pkg::FIFO_CW-1:0] in_flight;

    assign in_flight = fifo_count + lmaw_pkg::FIFO_CW'(work_valid);
    assign full      = in_flight >= lmaw_pkg::FIFO_CW'(lmaw_pkg::FIFO_DEPTH);
    assign accept    = push && !full;
    assign cfg_ready = 1'b1;

    lmaw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_item       (i_push_item),
        .o_work_valid (work_valid),
        .o_work       (work_in)
    );

    lmaw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_valid),
        .i_data  (work_in),
        .i_pop   (fifo_pop),
        .o_data  (work_out),
        .o_empty (fifo_empty),
        .o_count (fifo_count)
    );

    lmaw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!fifo_empty),
        .i_work       (work_out),
        .o_work_pop   (fifo_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_item       (o_pop_item)
    );

    a_no_queue_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        work_valid |-> (fifo_count < lmaw_pkg::FIFO_CW'(lmaw_pkg::FIFO_DEPTH)))
        else $error("work queue overrun");

    a_no_queue_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("work queue underrun");

    a_accept_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> work_valid)
        else $error("accepted beat did not enter the table-read stage");

endmodule

// ----- tb/tb_longest_majority_above_window.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the longest majority-above window block.

class window_checker;
    logic signed [lmaw_pkg::DATA_W-1:0] threshold;
    logic signed [lmaw_pkg::SUM_W-1:0]  run_sum;
    logic signed [lmaw_pkg::SUM_W-1:0]  low_sum;
    logic [lmaw_pkg::POS_W-1:0]         pos;
    logic [lmaw_pkg::POS_W-1:0]         best;
    logic [lmaw_pkg::IDX_W-1:0]         first_pos [lmaw_pkg::MAX_ITEMS];
    lmaw_pkg::t_out_item                expected_q [$];
    int errors;
    int n_items;
    int n_results;
    int n_ignored;
    int peak_best;

    function new();
        threshold = '0;
        clear_sequence();
        foreach (first_pos[k]) first_pos[k] = '0;
        errors    = 0;
        n_items   = 0;
        n_results = 0;
        n_ignored = 0;
        peak_best = 0;
    endfunction

    function void clear_sequence();
        run_sum = '0;
        low_sum = '0;
        pos     = '0;
        best    = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Work out the result that one accepted beat produces.
    function void note_item(lmaw_pkg::t_in_item it);
        lmaw_pkg::t_out_item want;
        int s;
        int i;
        int span;
        n_items++;
        if (it.first_item) clear_sequence();
        want = '0;
        if (int'(pos) >= lmaw_pkg::MAX_ITEMS) begin
            // capacity reached: hold all state, repeat the length
            want.best_length = best;
            want.overflow    = 1'b1;
            n_ignored++;
        end else begin
            i = int'(pos);
            s = int'(run_sum) + (($signed(it.sample_value) > threshold) ? 1 : -1);
            if (s > 0) begin
                best = lmaw_pkg::POS_W'(i + 1);
            end else if (s - 1 >= int'(low_sum)) begin
                span = i - int'(first_pos[-s]);
                if (span > int'(best)) best = lmaw_pkg::POS_W'(span);
            end
            if (s < int'(low_sum)) begin
                low_sum = lmaw_pkg::SUM_W'(s);
                first_pos[-s - 1] = lmaw_pkg::IDX_W'(i);
            end
            run_sum = lmaw_pkg::SUM_W'(s);
            pos     = lmaw_pkg::POS_W'(i + 1);
            want.best_length = best;
            if (int'(best) > peak_best) peak_best = int'(best);
        end
        expected_q.push_back(want);
    endfunction

    function void check_result(lmaw_pkg::t_out_item got);
        lmaw_pkg::t_out_item want;
        n_results++;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: best_length %0d overflow %0d",
                     $time, got.best_length, got.overflow);
            return;
        end
        want = expected_q.pop_front();
        if (got.best_length !== want.best_length) begin
            errors++;
            $display("%0t: best_length mismatch: expected %0d actual %0d",
                     $time, want.best_length, got.best_length);
        end
        if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0d actual %0d",
                     $time, want.overflow, got.overflow);
        end
    endfunction
endclass

module tb_longest_majority_above_window;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          push       = 1'b0;
    logic                          full;
    lmaw_pkg::t_in_item            in_item    = '0;
    logic                          empty;
    logic                          pop        = 1'b0;
    lmaw_pkg::t_out_item           out_item;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [lmaw_pkg::DATA_W-1:0]   cfg_data   = '0;

    window_checker sb = new();
    int burst_left = 0;
    int n_thr_writes = 0;

    longest_majority_above_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_push_item (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_pop_item  (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic lmaw_pkg::t_in_item mk_item(input logic [lmaw_pkg::DATA_W-1:0] v,
                                                   input logic f);
        lmaw_pkg::t_in_item it;
        it.sample_value = v;
        it.first_item   = f;
        return it;
    endfunction

    // Mostly values near the threshold, with extremes and raw noise mixed in.
    function automatic logic [lmaw_pkg::DATA_W-1:0] pick_sample(
        input logic signed [lmaw_pkg::DATA_W-1:0] thr,
        input int above_pct);
        longint v;
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return thr;
            default: begin
                if ($urandom_range(0, 99) < above_pct)
                    v = longint'(thr) + longint'($urandom_range(1, 5000));
                else
                    v = longint'(thr) - longint'($urandom_range(0, 5000));
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                return v[lmaw_pkg::DATA_W-1:0];
            end
        endcase
    endfunction

    task automatic send_item(input lmaw_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        burst_left--;
    endtask

    // Drain the block, then write the threshold.
    task automatic write_threshold(input logic [lmaw_pkg::DATA_W-1:0] v);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.threshold = v;
        n_thr_writes++;
    endtask

    task automatic run_sequence(input int len, input logic signed [lmaw_pkg::DATA_W-1:0] thr,
                                input int above_pct, input bit start_new);
        for (int k = 0; k < len; k++)
            send_item(mk_item(pick_sample(thr, above_pct), (k == 0) && start_new));
    endtask

    // Result side: pop on a changing stall pattern, with one long hold-off.
    initial begin : result_side
        int mode;
        int mode_left;
        logic [7:0] mask;
        bit held_off;
        mode      = 0;
        mode_left = 0;
        mask      = 8'hFF;
        held_off  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_result(out_item);
            if (!held_off && sb.n_results >= 150) begin
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
                mask      = 8'($urandom) | 8'h01;
            end
            mode_left--;
            case (mode)
                0: pop <= 1'b1;
                1: begin
                    pop  <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end
                default: pop <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    initial begin : stimulus
        logic signed [lmaw_pkg::DATA_W-1:0] thr;
        int items_left;
        int len;
        bit start_new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first item after reset carries no start flag
        send_item(mk_item(32'h0000_0000, 1'b0));
        send_item(mk_item(32'h0000_0001, 1'b0));
        send_item(mk_item(32'h7FFF_FFFF, 1'b0));
        send_item(mk_item(32'h8000_0000, 1'b0));
        send_item(mk_item(32'hFFFF_FFFF, 1'b0));
        send_item(mk_item(32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(32'h0000_0001, 1'b0));
        send_item(mk_item(32'h0000_0001, 1'b0));
        write_threshold(32'h7FFF_FFFF);
        send_item(mk_item(32'h7FFF_FFFF, 1'b1));
        send_item(mk_item(32'h8000_0000, 1'b0));
        send_item(mk_item(32'h0000_0000, 1'b0));
        write_threshold(32'h8000_0000);
        send_item(mk_item(32'h8000_0000, 1'b1));
        send_item(mk_item(32'h8000_0001, 1'b0));
        send_item(mk_item(32'h7FFF_FFFF, 1'b0));
        send_item(mk_item(32'h8000_0000, 1'b0));
        write_threshold(32'hFFFF_FFFF);
        send_item(mk_item(32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(32'h0000_0000, 1'b0));
        send_item(mk_item(32'hFFFF_FFFE, 1'b0));
        send_item(mk_item(32'h0000_0000, 1'b0));

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: thr = 32'h0000_0000;
                1: thr = 32'h7FFF_FFFF;
                2: thr = 32'h8000_0000;
                3: thr = 32'hFFFF_FFFF;
                5: thr = $urandom;
                6: thr = 32'h0000_0001;
                default: thr = $signed($urandom_range(0, 200)) - 100;
            endcase
            write_threshold(thr);
            // one sequence runs past capacity, then a few beats beyond it
            if (ph == 4) begin
                run_sequence(lmaw_pkg::MAX_ITEMS + $urandom_range(2, 8), thr, 50, 1'b1);
            end
            items_left = 20;
            start_new  = ($urandom_range(0, 3) != 0);
            while (items_left > 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 300)
                                                  : $urandom_range(1, 40);
                if (len > items_left) len = items_left;
                run_sequence(len, thr, $urandom_range(25, 80), start_new);
                items_left -= len;
                start_new = 1'b1;
            end
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("Run covered %0d items (%0d past capacity) over %0d threshold settings.",
                 sb.n_items, sb.n_ignored, n_thr_writes);
        $display("Checked %0d results; longest window %0d; %0d mismatches.",
                 sb.n_results, sb.peak_best, sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lmaw_pkg.sv
sv/lmaw_ram.sv
sv/lmaw_front.sv
sv/lmaw_fifo.sv
sv/lmaw_back.sv
sv/longest_majority_above_window.sv
tb/tb_longest_majority_above_window.sv
